/* rtl/ktt_pkg.sv */
`default_nettype none

package ktt_pkg;

    // Default build of the table
    localparam int SLOTS_DEF     = 16;
    localparam int KEY_CHARS_DEF = 8;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = KEY_W + TIME_W;   // {stamp, key}

    // Item kinds carried on tuser
    localparam logic MODE_PEEK  = 1'b0;
    localparam logic MODE_STAMP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_RESP
    } t_state;

    // Cut the key at its first zero byte and after chars characters
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k,
                                                   input int chars);
        logic [KEY_W-1:0] r;
        logic             stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= chars || k[8*i +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*i +: 8] = k[8*i +: 8];
            end
        end
        return r;
    endfunction

    // Fold A-Z to a-z in every byte
    function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = k;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] >= 8'h41 && k[8*i +: 8] <= 8'h5A) begin
                r[8*i +: 8] = k[8*i +: 8] + 8'h20;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ktt_ram.sv */
`default_nettype none

module ktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/keyed_timestamp_table_lru_top.sv */
`default_nettype none

// Channel    Dir  tdata                                  tuser
// s_axis     in   [63:0] key, [95:64] time_value         [0] mode
// m_axis     out  [31:0] last_time                       -
//
// Each item with a nonempty key walks all SLOTS entries of one RAM port,
// one read a cycle, through the single read port. An empty key skips the
// walk: a stamp is dropped and a peek answers zero.
// Reset clears the per-slot valid bits at once; no clearing pass.
// A peek answer waits in an output register; the table holds its next
// result until that register drains, and takes no new beat meanwhile.

module keyed_timestamp_table_lru_top #(
    parameter int SLOTS     = ktt_pkg::SLOTS_DEF,
    parameter int KEY_CHARS = ktt_pkg::KEY_CHARS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // [63:0] key, [95:64] time_value
    input  wire logic [0:0]  s_axis_tuser,   // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] last_time
);

    import ktt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state r_state, n_state;

    // Item registers
    logic              r_mode;
    logic [KEY_W-1:0]  r_key, r_fkey;
    logic [TIME_W-1:0] r_time;

    // Walk control
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0] r_cmp_idx;
    logic          r_rd_valid;
    logic [SLOTS-1:0] r_valid;

    // Search results
    logic              r_hit, r_free;
    logic [IW-1:0]     r_hit_idx, r_vic_idx;
    logic [TIME_W-1:0] r_hit_stamp, r_vic_stamp;
    logic [KEY_W-1:0]  r_hit_key;

    // Answer and output register
    logic [TIME_W-1:0] r_ans, n_ans;
    logic              r_out_vld;
    logic [TIME_W-1:0] r_out_data;
    logic              load_out;

    // RAM ports
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [KEY_W-1:0]  in_key;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_stamp;
    logic              rd_match;
    logic              in_acc;

    ktt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_key        = norm_key(s_axis_tdata[KEY_W-1:0], KEY_CHARS);

    // An entry that was never written reads as free with stamp zero
    assign rd_key   = r_rd_valid ? ram_rdata[KEY_W-1:0] : '0;
    assign rd_stamp = r_rd_valid ? ram_rdata[ENTRY_W-1:KEY_W] : '0;
    assign rd_match = r_rd_valid && (fold_key(rd_key) == r_fkey);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_rd_idx  <= n_rd_idx;
        end
    end

    // Next state, walk control, write-back and answer
    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = 1'b0;
        n_ans     = r_ans;
        ram_we    = 1'b0;
        ram_waddr = r_vic_idx;
        ram_wdata = {r_time, r_key};
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_rd_idx = '0;
                if (in_acc) begin
                    if (in_key != '0) begin
                        n_state = ST_SCAN;
                    end else if (s_axis_tuser[0] == MODE_PEEK) begin
                        n_ans   = '0;
                        n_state = ST_RESP;
                    end
                end
            end
            ST_SCAN: begin
                n_cmp_vld = 1'b1;
                if (r_rd_idx == IW'(SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last entry is compared in this cycle
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (r_mode == MODE_PEEK) begin
                    n_ans   = (r_hit && !(r_hit_stamp < r_time)) ? r_hit_stamp : r_time;
                    n_state = ST_RESP;
                end else begin
                    // write back: the next walk reads only after this write
                    ram_we = 1'b1;
                    if (r_hit) begin
                        ram_waddr = r_hit_idx;
                        ram_wdata = {r_time, r_hit_key};
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (!r_out_vld || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= s_axis_tuser[0];
            r_key  <= in_key;
            r_fkey <= fold_key(in_key);
            r_time <= s_axis_tdata[ENTRY_W-1:KEY_W];
        end
        r_ans      <= n_ans;
        r_cmp_idx  <= r_rd_idx;
        r_rd_valid <= r_valid[r_rd_idx];
    end

    // Track the first hit and the victim slot during the walk
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_cmp_vld) begin
            if (!r_hit && rd_match) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_cmp_idx;
                r_hit_stamp <= rd_stamp;
                r_hit_key   <= rd_key;
            end
            if (!r_free) begin
                if (!r_rd_valid) begin
                    r_free    <= 1'b1;
                    r_vic_idx <= r_cmp_idx;
                end else if (r_cmp_idx == '0 || rd_stamp < r_vic_stamp) begin
                    r_vic_idx   <= r_cmp_idx;
                    r_vic_stamp <= rd_stamp;
                end
            end
        end
    end

    // Mark a slot as used when a new key lands in it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we && !r_hit) begin
            r_valid[r_vic_idx] <= 1'b1;
        end
    end

    // Output register: hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= r_ans;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
